@@ hdl/rc2_pkg.sv @@
// Package for the RC2 block cipher engine: opcodes, widths and the key permutation.
// Used by the input and result channel interfaces, the engine top level, the checker and the testbench.
package rc2_pkg;

    localparam int KeyBytes = 128;
    localparam int KeyAw    = 7;

    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_ENC    = 2'd1;
    localparam logic [1:0] OP_DEC    = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef logic [1:0]  t_op;
    typedef logic [63:0] t_block;

    localparam logic [7:0] PiTab [256] = '{
        8'd217,8'd120,8'd249,8'd196,8'd25,8'd221,8'd181,8'd237,
        8'd40,8'd233,8'd253,8'd121,8'd74,8'd160,8'd216,8'd157,
        8'd198,8'd126,8'd55,8'd131,8'd43,8'd118,8'd83,8'd142,
        8'd98,8'd76,8'd100,8'd136,8'd68,8'd139,8'd251,8'd162,
        8'd23,8'd154,8'd89,8'd245,8'd135,8'd179,8'd79,8'd19,
        8'd97,8'd69,8'd109,8'd141,8'd9,8'd129,8'd125,8'd50,
        8'd189,8'd143,8'd64,8'd235,8'd134,8'd183,8'd123,8'd11,
        8'd240,8'd149,8'd33,8'd34,8'd92,8'd107,8'd78,8'd130,
        8'd84,8'd214,8'd101,8'd147,8'd206,8'd96,8'd178,8'd28,
        8'd115,8'd86,8'd192,8'd20,8'd167,8'd140,8'd241,8'd220,
        8'd18,8'd117,8'd202,8'd31,8'd59,8'd190,8'd228,8'd209,
        8'd66,8'd61,8'd212,8'd48,8'd163,8'd60,8'd182,8'd38,
        8'd111,8'd191,8'd14,8'd218,8'd70,8'd105,8'd7,8'd87,
        8'd39,8'd242,8'd29,8'd155,8'd188,8'd148,8'd67,8'd3,
        8'd248,8'd17,8'd199,8'd246,8'd144,8'd239,8'd62,8'd231,
        8'd6,8'd195,8'd213,8'd47,8'd200,8'd102,8'd30,8'd215,
        8'd8,8'd232,8'd234,8'd222,8'd128,8'd82,8'd238,8'd247,
        8'd132,8'd170,8'd114,8'd172,8'd53,8'd77,8'd106,8'd42,
        8'd150,8'd26,8'd210,8'd113,8'd90,8'd21,8'd73,8'd116,
        8'd75,8'd159,8'd208,8'd94,8'd4,8'd24,8'd164,8'd236,
        8'd194,8'd224,8'd65,8'd110,8'd15,8'd81,8'd203,8'd204,
        8'd36,8'd145,8'd175,8'd80,8'd161,8'd244,8'd112,8'd57,
        8'd153,8'd124,8'd58,8'd133,8'd35,8'd184,8'd180,8'd122,
        8'd252,8'd2,8'd54,8'd91,8'd37,8'd85,8'd151,8'd49,
        8'd45,8'd93,8'd250,8'd152,8'd227,8'd138,8'd146,8'd174,
        8'd5,8'd223,8'd41,8'd16,8'd103,8'd108,8'd186,8'd201,
        8'd211,8'd0,8'd230,8'd207,8'd225,8'd158,8'd168,8'd44,
        8'd99,8'd22,8'd1,8'd63,8'd88,8'd226,8'd137,8'd169,
        8'd13,8'd56,8'd52,8'd27,8'd171,8'd51,8'd255,8'd176,
        8'd187,8'd72,8'd12,8'd95,8'd185,8'd177,8'd205,8'd46,
        8'd197,8'd243,8'd219,8'd71,8'd229,8'd165,8'd156,8'd119,
        8'd10,8'd166,8'd32,8'd104,8'd254,8'd127,8'd193,8'd173
    };

endpackage

@@ hdl/rc2_if.sv @@
// Channel interfaces for the RC2 engine: input items, result items, config writes.
// Depends on rc2_pkg.
interface rc2_in_if;
    import rc2_pkg::*;
    logic         valid;
    logic         ready;
    t_op          op;
    logic [7:0]   key_byte;
    t_block       data_block;
    modport source (output valid, op, key_byte, data_block, input ready);
    modport sink   (input valid, op, key_byte, data_block, output ready);
endinterface

interface rc2_out_if;
    import rc2_pkg::*;
    logic         valid;
    logic         ready;
    t_block       result_block;
    modport source (output valid, result_block, input ready);
    modport sink   (input valid, result_block, output ready);
endinterface

interface rc2_cfg_if;
    logic         valid;
    logic         ready;
    logic [7:0]   data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

@@ hdl/rc2_block_cipher.sv @@
// RC2 engine top level: key store in a byte RAM, sequencer for load, expansion and rounds.
// Key-byte item: stored on accept; reaching the key length starts the key expansion.
// Block item: 72 steps (64 mix, 8 mash), each a key RAM read (S_RDK) and an update (S_STEP),
// then S_OUT loads the result register once it is free; no new item is accepted before that.
// Reset (i_rst_n low, synchronous) clears control state, fill count and key length 16.
// Depends on rc2_pkg, rc2_if and rc2_ram.
module rc2_block_cipher (
    input  logic i_clk,
    input  logic i_rst_n,
    rc2_cfg_if.sink  cfg,
    rc2_in_if.sink   in_ch,
    rc2_out_if.source out_ch
);
    import rc2_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXRD = 3'd1;
    localparam logic [2:0] S_EXWR = 3'd2;
    localparam logic [2:0] S_B0RD = 3'd3;
    localparam logic [2:0] S_B0WR = 3'd4;
    localparam logic [2:0] S_RDK  = 3'd5;
    localparam logic [2:0] S_STEP = 3'd6;
    localparam logic [2:0] S_OUT  = 3'd7;

    logic [2:0]   r_state, n_state;
    logic [7:0]   r_klen;
    logic [7:0]   r_fill, n_fill;
    logic [7:0]   r_t, n_t;
    logic [7:0]   r_idx, n_idx;
    logic         r_dec, n_dec;
    logic [6:0]   r_step, n_step;
    logic [15:0]  r_w [4];
    logic [15:0]  n_w [4];
    logic         r_ovld, n_ovld;
    t_block       r_res, n_res;

    logic         we;
    logic [6:0]   waddr, ra, rb;
    logic [7:0]   wdata, rda, rdb;

    rc2_ram #(.Width(8), .Depth(KeyBytes)) u_key (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr_a(ra), .i_raddr_b(rb), .o_rdata_a(rda), .o_rdata_b(rdb)
    );

    logic [7:0] eff_t;
    logic       is_mash;
    logic [5:0] round, kidx;
    logic [1:0] kk;
    logic [3:0] subi;
    logic [15:0] kw, a, b, c, f, x, y;

    always_comb begin
        eff_t = (r_klen == 8'd0) ? 8'd1 : ((r_klen > 8'd128) ? 8'd128 : r_klen);
        // Steps 0..71: within each group, encrypt order is mix rounds with mash slots.
        // The step counter walks a 72-entry schedule; decrypt walks it backwards.
        is_mash = 1'b0;
        round   = 6'd0;
        kk      = r_dec ? (2'd3 - r_step[1:0]) : r_step[1:0];
        begin : sched
            logic [6:0] s;
            s = r_dec ? (7'd71 - {r_step[6:2], 2'b00}) : {r_step[6:2], 2'b00};
            if (s < 7'd20) begin
                round = 6'(s[6:2]);
            end else if (s < 7'd24) begin
                is_mash = 1'b1;
            end else if (s < 7'd48) begin
                round = 6'(s[6:2] - 5'd1);
            end else if (s < 7'd52) begin
                is_mash = 1'b1;
            end else begin
                round = 6'(s[6:2] - 5'd2);
            end
        end
        subi = {round[3:0]};
        kidx = is_mash ? r_w[kk - 2'd1][5:0] : {subi, kk};
        kw   = {rdb, rda};
        a = r_w[kk + 2'd1];
        b = r_w[kk + 2'd2];
        c = r_w[kk + 2'd3];
        f = (a & ~c) + (b & c) + kw;
        x = r_w[kk] + f;
        y = r_w[kk];
        case (kk)
            2'd0:    y = {y[0], y[15:1]};
            2'd1:    y = {y[1:0], y[15:2]};
            2'd2:    y = {y[2:0], y[15:3]};
            default: y = {y[4:0], y[15:5]};
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_fill  = r_fill;
        n_t     = r_t;
        n_idx   = r_idx;
        n_dec   = r_dec;
        n_step  = r_step;
        n_w     = r_w;
        n_ovld  = r_ovld;
        n_res   = r_res;
        we      = 1'b0;
        waddr   = r_idx[6:0];
        wdata   = in_ch.key_byte;
        ra      = 7'({kidx, 1'b0});
        rb      = 7'({kidx, 1'b1});
        if (out_ch.ready) begin
            n_ovld = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (in_ch.valid) begin
                    if (in_ch.op == OP_LOAD) begin
                        we    = !r_fill[7];
                        waddr = r_fill[6:0];
                        if (r_fill + 8'd1 >= eff_t) begin
                            n_fill  = 8'd0;
                            n_t     = eff_t;
                            n_idx   = eff_t;
                            n_state = (eff_t == 8'd128) ? S_B0RD : S_EXRD;
                        end else begin
                            n_fill = r_fill + 8'd1;
                        end
                    end else if (in_ch.op == OP_ENC || in_ch.op == OP_DEC) begin
                        n_dec   = (in_ch.op == OP_DEC);
                        n_step  = 7'd0;
                        n_w[0]  = in_ch.data_block[63:48];
                        n_w[1]  = in_ch.data_block[47:32];
                        n_w[2]  = in_ch.data_block[31:16];
                        n_w[3]  = in_ch.data_block[15:0];
                        n_state = S_RDK;
                    end
                end
            end
            S_EXRD: begin
                ra      = 7'(r_idx - 8'd1);
                rb      = 7'(r_idx - r_t);
                n_state = S_EXWR;
            end
            S_EXWR: begin
                we    = 1'b1;
                wdata = PiTab[rda + rdb];
                if (r_idx == 8'd127) begin
                    n_state = S_B0RD;
                end else begin
                    n_idx   = r_idx + 8'd1;
                    n_state = S_EXRD;
                end
            end
            S_B0RD: begin
                ra      = 7'd0;
                n_state = S_B0WR;
            end
            S_B0WR: begin
                we      = 1'b1;
                waddr   = 7'd0;
                wdata   = PiTab[rda];
                n_state = S_IDLE;
            end
            S_RDK: begin
                n_state = S_STEP;
            end
            S_STEP: begin
                if (is_mash) begin
                    n_w[kk] = r_dec ? (r_w[kk] - kw) : (r_w[kk] + kw);
                end else if (r_dec) begin
                    n_w[kk] = y - f;
                end else begin
                    case (kk)
                        2'd0:    n_w[kk] = {x[14:0], x[15]};
                        2'd1:    n_w[kk] = {x[13:0], x[15:14]};
                        2'd2:    n_w[kk] = {x[12:0], x[15:13]};
                        default: n_w[kk] = {x[10:0], x[15:11]};
                    endcase
                end
                if (r_step == 7'd71) begin
                    n_state = S_OUT;
                end else begin
                    n_step  = r_step + 7'd1;
                    n_state = S_RDK;
                end
            end
            S_OUT: begin
                if (!r_ovld || out_ch.ready) begin
                    n_ovld  = 1'b1;
                    n_res   = {r_w[0], r_w[1], r_w[2], r_w[3]};
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Key addresses for the next step are presented in S_RDK from the registered step.
    assign in_ch.ready     = (r_state == S_IDLE);
    assign cfg.ready       = 1'b1;
    assign out_ch.valid    = r_ovld;
    assign out_ch.result_block = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_klen  <= 8'd16;
            r_fill  <= 8'd0;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_ovld  <= n_ovld;
            if (cfg.valid) begin
                r_klen <= cfg.data;
            end
        end
        r_t    <= n_t;
        r_idx  <= n_idx;
        r_dec  <= n_dec;
        r_step <= n_step;
        r_w    <= n_w;
        r_res  <= n_res;
    end
endmodule

@@ hdl/rc2_ram.sv @@
// Generic single-port-write, dual-read RAM with registered read data.
// No dependencies.
module rc2_ram #(
    parameter int Width = 8,
    parameter int Depth = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr_a,
    input  logic [$clog2(Depth)-1:0] i_raddr_b,
    output logic [Width-1:0]         o_rdata_a,
    output logic [Width-1:0]         o_rdata_b
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end
endmodule

@@ hdl/rc2_checker.sv @@
// Port-level checker for rc2_block_cipher, attached by bind.
// Depends on rc2_pkg and the channel interfaces.
module rc2_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         in_valid,
    input logic         in_ready,
    input logic [1:0]   in_op,
    input logic         out_valid,
    input logic         out_ready,
    input logic [63:0]  out_data
);
    import rc2_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result item changed while stalled");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && in_ready && (in_op == OP_ENC || in_op == OP_DEC) |=> !in_ready)
        else $error("block item accepted while busy");

    a_noout: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && in_ready && in_op == OP_LOAD && !out_valid |=> !out_valid)
        else $error("result item from key load");

    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !out_valid)
        else $error("result valid after reset");
endmodule

bind rc2_block_cipher rc2_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_op(in_ch.op),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.result_block)
);

@@ bench/tb.sv @@
// Self-checking testbench for the RC2 engine: key loading, encryption and decryption.
// Depends on rc2_pkg, rc2_if and the rc2_block_cipher RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import rc2_pkg::*;

    class rc2_scoreboard;
        logic [7:0] key_store [KeyBytes];
        logic [7:0] fill_count;
        logic [7:0] key_len;
        t_block     pending_blocks [$];
        int         error_count;
        int         block_count;

        function new();
            fill_count = 0;
            key_len = 16;
            error_count = 0;
            block_count = 0;
            foreach (key_store[i]) key_store[i] = 0;
        endfunction

        function logic [15:0] key_word(int j);
            j = j & 63;
            return {key_store[2 * j + 1], key_store[2 * j]};
        endfunction

        function void expand_key(int t);
            for (int i = t; i < KeyBytes; i++) begin
                key_store[i] = PiTab[8'(key_store[i - 1] + key_store[i - t])];
            end
            key_store[0] = PiTab[key_store[0]];
        endfunction

        function t_block cipher(t_op op, t_block blk);
            logic [15:0] r [4];
            logic [15:0] f;
            logic [15:0] x;
            int rot [4];
            rot = '{1, 2, 3, 5};
            for (int w = 0; w < 4; w++) r[w] = blk[63 - 16 * w -: 16];
            if (op == OP_ENC) begin
                for (int i = 0; i < 16; i++) begin
                    for (int k = 0; k < 4; k++) begin
                        f = (r[(k + 1) % 4] & ~r[(k + 3) % 4]) + (r[(k + 2) % 4] & r[(k + 3) % 4])
                            + key_word(4 * i + k);
                        x = r[k] + f;
                        r[k] = (x << rot[k]) | (x >> (16 - rot[k]));
                    end
                    if (i == 4 || i == 10) begin
                        for (int k = 0; k < 4; k++) r[k] = r[k] + key_word(r[(k + 3) % 4] & 63);
                    end
                end
            end else begin
                for (int i = 15; i >= 0; i--) begin
                    for (int k = 3; k >= 0; k--) begin
                        f = (r[(k + 1) % 4] & ~r[(k + 3) % 4]) + (r[(k + 2) % 4] & r[(k + 3) % 4])
                            + key_word(4 * i + k);
                        x = (r[k] >> rot[k]) | (r[k] << (16 - rot[k]));
                        r[k] = x - f;
                    end
                    if (i == 5 || i == 11) begin
                        for (int k = 3; k >= 0; k--) r[k] = r[k] - key_word(r[(k + 3) % 4] & 63);
                    end
                end
            end
            return {r[0], r[1], r[2], r[3]};
        endfunction

        function void note_input(t_op op, logic [7:0] kb, t_block blk);
            int t;
            int idx;
            if (op == OP_LOAD) begin
                t = (key_len == 0) ? 1 : (key_len > KeyBytes ? KeyBytes : key_len);
                idx = fill_count;
                if (idx < KeyBytes) key_store[idx] = kb;
                idx++;
                if (idx >= t) begin
                    expand_key(t);
                    idx = 0;
                end
                fill_count = 8'(idx);
            end else if (op == OP_ENC || op == OP_DEC) begin
                pending_blocks.push_back(cipher(op, blk));
            end
        endfunction

        function void check_result(t_block got);
            t_block exp_blk;
            block_count++;
            if (pending_blocks.size() == 0) begin
                $error("result_block: none expected, actual %h", got);
                error_count++;
                return;
            end
            exp_blk = pending_blocks.pop_front();
            if (got !== exp_blk) begin
                $error("result_block: expected %h, actual %h", exp_blk, got);
                error_count++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    rc2_cfg_if cfg ();
    rc2_in_if in_ch ();
    rc2_out_if out_ch ();

    rc2_block_cipher i_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .cfg(cfg.sink),
        .in_ch(in_ch.sink),
        .out_ch(out_ch.source)
    );

    rc2_scoreboard board;
    int idle_cycles;
    bit sink_idle_mode;
    int phase_blocks;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic int idle_draw();
        return (phase_blocks % 5 == 4) ? 0 : $urandom_range(0, 6);
    endfunction

    task automatic send_item(t_op op, logic [7:0] kb, t_block blk);
        int n;
        n = idle_draw();
        if (n > 0) begin
            in_ch.valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.op <= op;
        in_ch.key_byte <= kb;
        in_ch.data_block <= blk;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        board.note_input(op, kb, blk);
    endtask

    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (board.pending_blocks.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic write_key_length(logic [7:0] len);
        cfg.valid <= 1'b1;
        cfg.data <= len;
        @(posedge i_clk);
        while (!cfg.ready) @(posedge i_clk);
        board.key_len = len;
        cfg.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic load_key(int count);
        for (int i = 0; i < count; i++) send_item(OP_LOAD, 8'($urandom), '0);
    endtask

    function automatic t_block rand_block();
        return {$urandom, $urandom};
    endfunction

    task automatic random_blocks(int count);
        t_op op;
        for (int i = 0; i < count; i++) begin
            phase_blocks++;
            op = ($urandom_range(0, 1) == 0) ? OP_ENC : OP_DEC;
            if ($urandom_range(0, 19) == 0) op = OP_UNUSED;
            send_item(op, 8'($urandom), rand_block());
        end
    endtask

    // Result side: random stall per item, with some stretches of constant ready.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            idle_cycles <= 0;
        end else begin
            if (out_ch.valid && out_ch.ready) board.check_result(out_ch.result_block);
            if (idle_cycles > 0) begin
                idle_cycles <= idle_cycles - 1;
                out_ch.ready <= 1'b0;
            end else if (out_ch.valid && out_ch.ready) begin
                if (sink_idle_mode) begin
                    idle_cycles <= $urandom_range(0, 6);
                    out_ch.ready <= 1'b0;
                end
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    int stall_count;
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
            || (cfg.valid && cfg.ready)) begin
            stall_count <= 0;
        end else begin
            stall_count <= stall_count + 1;
            if (stall_count > 20000) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial begin
        board = new();
        phase_blocks = 0;
        sink_idle_mode = 1'b1;
        i_rst_n = 1'b0;
        cfg.valid = 1'b0;
        cfg.data = '0;
        in_ch.valid = 1'b0;
        in_ch.op = OP_LOAD;
        in_ch.key_byte = '0;
        in_ch.data_block = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part with the reset key length.
        load_key(16);
        send_item(OP_ENC, '0, '0);
        send_item(OP_ENC, '0, '1);
        send_item(OP_DEC, '0, '0);
        send_item(OP_DEC, '0, '1);
        send_item(OP_ENC, '0, 64'h8000_0000_0000_0001);
        send_item(OP_UNUSED, 8'hFF, '1);
        send_item(OP_DEC, '0, 64'h5555_AAAA_5555_AAAA);
        wait_idle();

        // Key length extremes and out-of-range values, then random phases.
        write_key_length(8'd1);
        send_item(OP_LOAD, 8'h00, '0);
        send_item(OP_ENC, '0, rand_block());
        send_item(OP_LOAD, 8'hFF, '0);
        random_blocks(40);
        wait_idle();
        write_key_length(8'd128);
        load_key(128);
        random_blocks(60);
        wait_idle();
        write_key_length(8'd0);
        load_key(1);
        random_blocks(60);
        wait_idle();
        write_key_length(8'd255);
        load_key(128);
        sink_idle_mode = 1'b0;
        random_blocks(60);
        wait_idle();
        sink_idle_mode = 1'b1;
        write_key_length(8'(10 + $urandom_range(0, 20)));
        load_key(5);
        random_blocks(30);
        load_key(40);
        random_blocks(60);
        wait_idle();
        for (int k = 0; k < 2; k++) begin
            write_key_length(8'($urandom_range(1, 128)));
            load_key(128);
            random_blocks(30);
            wait_idle();
        end

        $display("Covered %0d result items over key lengths 1 to 128 and out-of-range settings.",
                 board.block_count);
        if (board.error_count == 0 && board.pending_blocks.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule

@@ files.f @@
hdl/rc2_pkg.sv
hdl/rc2_if.sv
hdl/rc2_ram.sv
hdl/rc2_block_cipher.sv
hdl/rc2_checker.sv
bench/tb.sv
